/* hdl/smsd_pkg.sv */
package smsd_pkg;

    localparam int SAMPLE_W = 20;
    localparam int COUNT_W  = 11;
    localparam int Q4_W     = 24;
    localparam int ACC_W    = 64;
    localparam int ROOT_W   = 32;

    localparam logic [31:0] COUNT_MAX = 32'd2047;
    localparam logic [31:0] Q4_MAX    = 32'h00FF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_MDIV,
        ST_DEV,
        ST_VDIV,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic store;
        logic pass_start;
        logic pass_run;
        logic square;
        logic div_start;
        logic mean_load;
        logic sqrt_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic pass_done;
        logic div_busy;
        logic sqrt_busy;
    } status_t;

endpackage

/* hdl/sample_mean_std_dev.sv */
// Population mean and standard deviation of a set of unsigned samples. Each
// item is taken while the block is idle and writes its sample into an
// on-chip store of MAX_SAMPLES entries; samples past the store depth are
// dropped and flagged. The item with last set closes the set and starts the
// computation, which reads the store twice through its single read port: a
// summing pass, a divide for the mean, a squaring pass, a divide for the
// variance and a square root, the divides and the root bit-serial, and a
// load of the result that waits while an earlier result still waits; an
// empty set goes straight to that load. No item is taken during that time.
// The result carries the count, the mean and the deviation, both unsigned
// with 4 fraction bits, and waits in an output register, so samples of the
// next set are taken while it is held.
module sample_mean_std_dev #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [smsd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [smsd_pkg::COUNT_W-1:0]    sample_count,
    output logic [smsd_pkg::Q4_W-1:0]       mean_q4,
    output logic [smsd_pkg::Q4_W-1:0]       std_dev_q4,
    output logic                            dropped,
    output logic                            empty_set
);

    smsd_pkg::cmd_t    cmd;
    smsd_pkg::status_t status;

    smsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    smsd_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .sample_count (sample_count),
        .mean_q4      (mean_q4),
        .std_dev_q4   (std_dev_q4),
        .dropped      (dropped),
        .empty_set    (empty_set)
    );

endmodule

/* hdl/smsd_ram.sv */
module smsd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/smsd_div.sv */
module smsd_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, q_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            q_next   = numer;
            rem_next = '0;
            den_next = denom;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            // one quotient bit per cycle, restoring
            q_next   = {q_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule

/* hdl/smsd_sqrt.sv */
module smsd_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [smsd_pkg::ACC_W-1:0]   radicand,
    output logic                         busy,
    output logic [smsd_pkg::ROOT_W-1:0]  root
);

    localparam int XW    = smsd_pkg::ACC_W;
    localparam int RW    = smsd_pkg::ROOT_W;
    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [XW-1:0]    x_reg, x_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             ge;

    // remainder never exceeds twice the partial root, so its top two bits are zero
    assign shifted = {rem_reg[RW-1:0], x_reg[XW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign ge      = shifted >= trial;

    always_comb
    begin
        x_next    = x_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            x_next    = radicand;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(RW);
        end
        else if (cnt_reg != '0)
        begin
            x_next    = {x_reg[XW-3:0], 2'b00};
            root_next = {root_reg[RW-2:0], ge};
            rem_next  = ge ? shifted - trial : shifted;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign busy = cnt_reg != '0;
    assign root = root_reg;

endmodule

/* hdl/smsd_datapath.sv */
module smsd_datapath #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [smsd_pkg::SAMPLE_W-1:0]   sample,
    input  smsd_pkg::cmd_t                  cmd,
    output smsd_pkg::status_t               status,
    output logic [smsd_pkg::COUNT_W-1:0]    sample_count,
    output logic [smsd_pkg::Q4_W-1:0]       mean_q4,
    output logic [smsd_pkg::Q4_W-1:0]       std_dev_q4,
    output logic                            dropped,
    output logic                            empty_set
);

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int MW   = SAMPLE_BITS + 4;
    localparam int SQW  = 2 * MW;
    localparam int ACCW = smsd_pkg::ACC_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

    logic [CW-1:0]          kept_count_reg, kept_count_next;
    logic                   overflow_reg, overflow_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   v1_reg, v1_next;
    logic                   v2_reg, v2_next;
    logic                   v3_reg, v3_next;
    logic [ACCW-1:0]        acc_reg, acc_next;
    logic [MW-1:0]          d_reg, d_next;
    logic [SQW-1:0]         sq_reg, sq_next;
    logic [MW-1:0]          mean_reg, mean_next;
    logic [smsd_pkg::COUNT_W-1:0] count_out_reg, count_out_next;
    logic [smsd_pkg::Q4_W-1:0]    mean_out_reg, mean_out_next;
    logic [smsd_pkg::Q4_W-1:0]    dev_out_reg, dev_out_next;
    logic                   dropped_reg, dropped_next;
    logic                   empty_reg, empty_next;

    logic [SAMPLE_BITS-1:0] s_in;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   full;
    logic                   wr_en;
    logic                   issue;
    logic [MW-1:0]          x_q4;
    logic [ACCW:0]          sq_sum;
    logic [ACCW-1:0]        div_numer;
    logic [ACCW-1:0]        quotient;
    logic [smsd_pkg::ROOT_W-1:0] root;
    logic                   div_busy;
    logic                   sqrt_busy;

    assign s_in  = SAMPLE_BITS'(sample);
    assign full  = kept_count_reg == MAX_CNT;
    assign wr_en = cmd.store && !full;
    assign issue = cmd.pass_run && (rd_idx_reg != kept_count_reg);

    smsd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (kept_count_reg[AW-1:0]),
        .wdata (s_in),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign div_numer = cmd.square ? acc_reg : {acc_reg[ACCW-5:0], 4'b0000};

    smsd_div #(
        .NUM_W (ACCW),
        .DEN_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .numer    (div_numer),
        .denom    (kept_count_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    smsd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (quotient),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign x_q4   = {rd_data, 4'b0000};
    assign sq_sum = {1'b0, acc_reg} + (ACCW + 1)'(sq_reg);

    // set bookkeeping and the read pipeline
    always_comb
    begin
        kept_count_next = kept_count_reg;
        overflow_next   = overflow_reg;
        if (cmd.load_out)
        begin
            kept_count_next = '0;
            overflow_next   = 1'b0;
        end
        else if (cmd.store)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                kept_count_next = kept_count_reg + 1'b1;
            end
        end

        rd_idx_next = (cmd.pass_start || cmd.load_out) ? '0 : rd_idx_reg + CW'(issue);
        v1_next     = issue;
        v2_next     = v1_reg && cmd.square;
        v3_next     = v2_reg;
        if (cmd.pass_start)
        begin
            v1_next = 1'b0;
            v2_next = 1'b0;
            v3_next = 1'b0;
        end
    end

    // accumulate: plain sum on the first pass, saturating sum of squares on the second
    always_comb
    begin
        acc_next  = acc_reg;
        d_next    = d_reg;
        sq_next   = sq_reg;
        mean_next = mean_reg;
        if (cmd.pass_start)
        begin
            acc_next = '0;
        end
        else if (v1_reg && !cmd.square)
        begin
            acc_next = acc_reg + ACCW'(rd_data);
        end
        else if (v3_reg)
        begin
            acc_next = sq_sum[ACCW] ? '1 : sq_sum[ACCW-1:0];
        end
        if (v1_reg)
        begin
            d_next = (x_q4 >= mean_reg) ? x_q4 - mean_reg : mean_reg - x_q4;
        end
        if (v2_reg)
        begin
            sq_next = d_reg * d_reg;
        end
        if (cmd.mean_load)
        begin
            mean_next = quotient[MW-1:0];
        end
    end

    // result register
    always_comb
    begin
        count_out_next = count_out_reg;
        mean_out_next  = mean_out_reg;
        dev_out_next   = dev_out_reg;
        dropped_next   = dropped_reg;
        empty_next     = empty_reg;
        if (cmd.load_out)
        begin
            if (32'(kept_count_reg) > smsd_pkg::COUNT_MAX)
            begin
                count_out_next = smsd_pkg::COUNT_W'(smsd_pkg::COUNT_MAX);
            end
            else
            begin
                count_out_next = smsd_pkg::COUNT_W'(kept_count_reg);
            end
            if (status.count_zero)
            begin
                mean_out_next = '0;
                dev_out_next  = '0;
            end
            else
            begin
                if (32'(mean_reg) > smsd_pkg::Q4_MAX)
                begin
                    mean_out_next = smsd_pkg::Q4_W'(smsd_pkg::Q4_MAX);
                end
                else
                begin
                    mean_out_next = smsd_pkg::Q4_W'(mean_reg);
                end
                if (root > smsd_pkg::Q4_MAX)
                begin
                    dev_out_next = smsd_pkg::Q4_W'(smsd_pkg::Q4_MAX);
                end
                else
                begin
                    dev_out_next = root[smsd_pkg::Q4_W-1:0];
                end
            end
            dropped_next = overflow_reg;
            empty_next   = status.count_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg <= '0;
            overflow_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            kept_count_reg <= kept_count_next;
            overflow_reg   <= overflow_next;
            rd_idx_reg     <= rd_idx_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            v3_reg         <= v3_next;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        mean_reg      <= mean_next;
        count_out_reg <= count_out_next;
        mean_out_reg  <= mean_out_next;
        dev_out_reg   <= dev_out_next;
        dropped_reg   <= dropped_next;
        empty_reg     <= empty_next;
    end

    assign status.count_zero = kept_count_reg == '0;
    assign status.pass_done  = (rd_idx_reg == kept_count_reg) && !v1_reg && !v2_reg && !v3_reg;
    assign status.div_busy   = div_busy;
    assign status.sqrt_busy  = sqrt_busy;

    assign sample_count = count_out_reg;
    assign mean_q4      = mean_out_reg;
    assign std_dev_q4   = dev_out_reg;
    assign dropped      = dropped_reg;
    assign empty_set    = empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= MAX_CNT)
        else $error("kept count beyond store depth");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= kept_count_reg)
        else $error("read index past kept count");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (kept_count_reg == '0) && !overflow_reg)
        else $error("set not cleared after result load");
`endif

endmodule

/* hdl/smsd_ctrl.sv */
module smsd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    input  smsd_pkg::status_t   status,
    output smsd_pkg::cmd_t      cmd
);

    smsd_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smsd_pkg::ST_IDLE:
            begin
                if (in_valid && last)
                begin
                    state_next = smsd_pkg::ST_CHECK;
                end
            end
            smsd_pkg::ST_CHECK:
            begin
                state_next = status.count_zero ? smsd_pkg::ST_DONE : smsd_pkg::ST_SUM;
            end
            smsd_pkg::ST_SUM:
            begin
                if (status.pass_done)
                begin
                    state_next = smsd_pkg::ST_MDIV;
                end
            end
            smsd_pkg::ST_MDIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = smsd_pkg::ST_DEV;
                end
            end
            smsd_pkg::ST_DEV:
            begin
                if (status.pass_done)
                begin
                    state_next = smsd_pkg::ST_VDIV;
                end
            end
            smsd_pkg::ST_VDIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = smsd_pkg::ST_ROOT;
                end
            end
            smsd_pkg::ST_ROOT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = smsd_pkg::ST_DONE;
                end
            end
            smsd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = smsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            smsd_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
            end
            smsd_pkg::ST_CHECK:
            begin
                cmd.pass_start = !status.count_zero;
            end
            smsd_pkg::ST_SUM:
            begin
                cmd.pass_run  = 1'b1;
                cmd.div_start = status.pass_done;
            end
            smsd_pkg::ST_MDIV:
            begin
                cmd.mean_load  = !status.div_busy;
                cmd.pass_start = !status.div_busy;
            end
            smsd_pkg::ST_DEV:
            begin
                cmd.pass_run  = 1'b1;
                cmd.square    = 1'b1;
                cmd.div_start = status.pass_done;
            end
            smsd_pkg::ST_VDIV:
            begin
                cmd.sqrt_start = !status.div_busy;
            end
            smsd_pkg::ST_ROOT:
            begin
                cmd = '0;
            end
            smsd_pkg::ST_DONE:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smsd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |-> !status.sqrt_busy)
        else $error("root unit started while busy");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == smsd_pkg::ST_DONE))
        else $error("result raised outside of done state");
`endif

endmodule

/* tb/sv/smsd_stats_check.sv */
`timescale 1ns / 100ps

module smsd_stats_check #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [smsd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            last,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [smsd_pkg::COUNT_W-1:0]    sample_count,
    input  logic [smsd_pkg::Q4_W-1:0]       mean_q4,
    input  logic [smsd_pkg::Q4_W-1:0]       std_dev_q4,
    input  logic                            dropped,
    input  logic                            empty_set,
    output int                              errors,
    output int                              waiting
);

    localparam longint unsigned SAMPLE_MASK = (64'd1 << SAMPLE_BITS) - 1;

    typedef struct {
        bit [smsd_pkg::COUNT_W-1:0] count;
        bit [smsd_pkg::Q4_W-1:0]    mean;
        bit [smsd_pkg::Q4_W-1:0]    dev;
        bit                         dropped;
        bit                         empty;
    } set_stats_t;

    bit [smsd_pkg::SAMPLE_W-1:0] held [MAX_SAMPLES];
    int unsigned       held_n;
    bit                spill;
    set_stats_t        stats_q [$];
    int                err_n;

    function automatic bit [63:0] floor_root(bit [63:0] v);
        bit [63:0] root;
        bit [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= {64'd0, v})
                root = trial;
        end
        return root;
    endfunction

    function automatic bit [63:0] clip(bit [63:0] v, bit [63:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // Mean over the kept samples, then the root of the mean squared offset.
    function automatic set_stats_t close_set();
        set_stats_t r;
        bit [63:0]  total;
        bit [63:0]  mean_full;
        bit [63:0]  acc;
        bit [63:0]  x;
        bit [63:0]  d;
        bit [63:0]  sq;
        bit [63:0]  dev_full;
        total     = '0;
        mean_full = '0;
        acc       = '0;
        dev_full  = '0;
        if (held_n != 0)
        begin
            for (int i = 0; i < held_n; i++)
                total += 64'(held[i]);
            mean_full = (total << 4) / held_n;
            for (int i = 0; i < held_n; i++)
            begin
                x  = 64'(held[i]) << 4;
                d  = (x >= mean_full) ? x - mean_full : mean_full - x;
                sq = d * d;
                acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
            end
            dev_full = floor_root(acc / held_n);
        end
        r.count   = smsd_pkg::COUNT_W'(clip(64'(held_n), 64'(smsd_pkg::COUNT_MAX)));
        r.mean    = smsd_pkg::Q4_W'(clip(mean_full, 64'(smsd_pkg::Q4_MAX)));
        r.dev     = smsd_pkg::Q4_W'(clip(dev_full, 64'(smsd_pkg::Q4_MAX)));
        r.dropped = spill;
        r.empty   = (held_n == 0);
        return r;
    endfunction

    task automatic report(string msg);
        $display("%0t ns: %s", $realtime, msg);
        err_n++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        set_stats_t want;
        if (!rst_n)
        begin
            held_n = 0;
            spill  = 1'b0;
            err_n  = 0;
            stats_q.delete();
            errors  <= 0;
            waiting <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                // Drop samples once the store is full, but still honor last.
                if (held_n < MAX_SAMPLES)
                begin
                    held[held_n] = smsd_pkg::SAMPLE_W'(sample & SAMPLE_MASK);
                    held_n++;
                end
                else
                    spill = 1'b1;
                if (last)
                begin
                    stats_q.push_back(close_set());
                    held_n = 0;
                    spill  = 1'b0;
                end
            end
            if (out_valid && out_ready)
            begin
                if (stats_q.size() == 0)
                    report($sformatf("result with none pending: count %0d mean %0d dev %0d",
                                     sample_count, mean_q4, std_dev_q4));
                else
                begin
                    want = stats_q.pop_front();
                    check_field("sample_count", 64'(sample_count), 64'(want.count));
                    check_field("mean_q4", 64'(mean_q4), 64'(want.mean));
                    check_field("std_dev_q4", 64'(std_dev_q4), 64'(want.dev));
                    check_field("dropped", 64'(dropped), 64'(want.dropped));
                    check_field("empty_set", 64'(empty_set), 64'(want.empty));
                end
            end
            errors  <= err_n;
            waiting <= stats_q.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH         = 1024;
    localparam int SBITS         = 20;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 300;
    // Longest quiet stretch: a full store pass pair plus divides, root and stalls.
    localparam int QUIET_LIMIT   = 12000;

    localparam logic [smsd_pkg::SAMPLE_W-1:0] TOP = '1;

    typedef enum {FILL_ANY, FILL_LOW, FILL_NEAR, FILL_EDGE} fill_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [smsd_pkg::SAMPLE_W-1:0] sample = '0;
    logic                   last      = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [smsd_pkg::COUNT_W-1:0] sample_count;
    logic [smsd_pkg::Q4_W-1:0]    mean_q4;
    logic [smsd_pkg::Q4_W-1:0]    std_dev_q4;
    logic                   dropped;
    logic                   empty_set;
    int                     errors;
    int                     waiting;
    int                     quiet     = 0;
    bit                     no_gaps   = 1'b0;

    sample_mean_std_dev #(
        .MAX_SAMPLES(DEPTH),
        .SAMPLE_BITS(SBITS)
    ) dut (.*);

    smsd_stats_check #(
        .MAX_SAMPLES(DEPTH),
        .SAMPLE_BITS(SBITS)
    ) stats_check (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return 0;
        if (pick < 85)
            return $urandom_range(3, 1);
        if (pick < 97)
            return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic logic [smsd_pkg::SAMPLE_W-1:0] fill_value(fill_t mode,
                                                                 logic [smsd_pkg::SAMPLE_W-1:0] base);
        case (mode)
            FILL_LOW:  return smsd_pkg::SAMPLE_W'($urandom_range(15));
            FILL_NEAR: return base ^ smsd_pkg::SAMPLE_W'($urandom_range(63));
            FILL_EDGE: return ($urandom_range(1) == 1) ? TOP : '0;
            default:   return smsd_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    // Hold the item until it is taken; keep valid high across back-to-back items.
    task automatic send(input logic [smsd_pkg::SAMPLE_W-1:0] value, input logic mark);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        last     <= mark;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_set(int n, fill_t mode);
        logic [smsd_pkg::SAMPLE_W-1:0] base;
        base = smsd_pkg::SAMPLE_W'($urandom());
        for (int i = 1; i <= n; i++)
            send(fill_value(mode, base), i == n);
    endtask

    initial
    begin
        int    random_sent;
        int    big_at;
        int    n;
        int    pick;
        bit    big_done;
        fill_t mode;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-sample sets at both ends of the range.
        send('0, 1'b1);
        send(TOP, 1'b1);
        // Widest spread, then a flat set at full scale.
        send('0, 1'b0);
        send(TOP, 1'b1);
        send(TOP, 1'b0);
        send(TOP, 1'b0);
        send(TOP, 1'b1);
        // Means with a fraction, two of them truncated.
        send(20'd1, 1'b0);
        send(20'd2, 1'b0);
        send(20'd3, 1'b0);
        send(20'd4, 1'b1);
        send(20'd5, 1'b0);
        send(20'd6, 1'b0);
        send(20'd6, 1'b1);
        send(20'hAAAAA, 1'b0);
        send(20'h55555, 1'b1);
        send('0, 1'b0);
        send('0, 1'b0);
        send(20'h80000, 1'b1);

        // Mostly short sets; one set overruns the store to force drops.
        random_sent = 0;
        big_done    = 1'b0;
        big_at      = $urandom_range(800, 200);
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (!big_done && random_sent >= big_at)
            begin
                n        = DEPTH + $urandom_range(6, 1);
                big_done = 1'b1;
            end
            else if (pick < 70)
                n = $urandom_range(6, 1);
            else if (pick < 92)
                n = $urandom_range(30, 7);
            else
                n = $urandom_range(100, 31);
            mode    = fill_t'($urandom_range(FILL_EDGE));
            no_gaps = ($urandom_range(4) == 0);
            send_set(n, mode);
            random_sent += n;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: runs of ready, mostly short, with stalls in between.
    initial
    begin
        int run;
        forever
        begin
            run = ($urandom_range(9) == 0) ? $urandom_range(300, 50) : $urandom_range(12, 1);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            run = idle_len();
            if (run > 0)
            begin
                out_ready <= 1'b0;
                repeat (run) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

endmodule
